### sv/ptbs_pkg.sv
`timescale 1ns / 1ps

package ptbs_pkg;

  // Widths fixed by the result fields and the task counter.
  localparam int TASK_W = 8;
  localparam int CNT_W  = 9;
  localparam int TIME_W = 16;
  localparam int OP_W   = 2;
  localparam int EVT_W  = 32;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_DONE = 2'd2;

  // Item context held steady while the update wave walks the cells.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] dly;
    logic [TIME_W-1:0] per;
    logic [CNT_W-1:0]  count;
    logic [TASK_W-1:0] running;
  } item_t;

  // Token handed from one cell to the next.
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [TASK_W-1:0] idx;
  } wave_t;

endpackage

### sv/periodic_task_bitmap_scheduler.sv
`timescale 1ns / 1ps
// Periodic task scheduler with one slot per task; the slot index is its priority.
// Input channel (in_valid_i / in_ready_o) moves one operation per transfer:
// a tick, an add of a task with start delay and reload period, or a done of
// the running task. Each transfer yields exactly one result transfer on the
// output channel (out_valid_o / out_ready_i).
// From input transfer to a visible result, a single token walks the row of
// MAX_TASKS task cells, one cell per cycle, updating each slot and carrying
// the lowest ready index found so far. The walk through the cell row sets
// both latency and throughput; one item is in flight at a time, so a new
// item is taken only once the walk of the last one has retired.
// The result sits in an output register, so the next item is accepted while
// a result waits. If the receiver stalls, the finished walk is parked until
// the output register frees up, and no further item is accepted meanwhile.
// Reset clears all ready bits, the task count, the running task (idle task)
// and both event counters; periods are written by adds only, delays also by ticks.
module periodic_task_bitmap_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptbs_pkg::OP_W-1:0]     op_i,
  input  logic [ptbs_pkg::TIME_W-1:0]   start_delay_i,
  input  logic [ptbs_pkg::TIME_W-1:0]   reload_period_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptbs_pkg::TASK_W-1:0]   highest_task_o,
  output logic [ptbs_pkg::TASK_W-1:0]   current_task_o,
  output logic                          switch_now_o,
  output logic                          add_ok_o,
  output logic [ptbs_pkg::EVT_W-1:0]    idle_count_o,
  output logic [ptbs_pkg::EVT_W-1:0]    switch_count_o
);

  localparam logic [ptbs_pkg::CNT_W-1:0] MaxCnt = ptbs_pkg::CNT_W'(MAX_TASKS);

  // Control state.
  logic                          busy_q, busy_d;
  logic                          start_q;
  logic                          pend_q, pend_d;
  logic                          out_valid_q, out_valid_d;
  logic [ptbs_pkg::CNT_W-1:0]    count_q, count_d;
  logic [ptbs_pkg::TASK_W-1:0]   running_q, running_d;
  logic [ptbs_pkg::EVT_W-1:0]    idle_q, idle_d;
  logic [ptbs_pkg::EVT_W-1:0]    switch_q, switch_d;

  // Item and result payload.
  logic [ptbs_pkg::OP_W-1:0]     op_q;
  logic [ptbs_pkg::TIME_W-1:0]   dly_q;
  logic [ptbs_pkg::TIME_W-1:0]   per_q;
  logic [ptbs_pkg::TASK_W-1:0]   best_q, best_d;
  logic                          sw_q, sw_d;
  logic                          added_q, added_d;

  logic                          in_xfer;
  logic                          finish;
  ptbs_pkg::item_t               item;
  ptbs_pkg::wave_t               wave [MAX_TASKS+1];

  assign in_ready_o = !busy_q;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign item.op      = op_q;
  assign item.dly     = dly_q;
  assign item.per     = per_q;
  assign item.count   = count_q;
  assign item.running = running_q;

  // The token enters cell zero in the cycle after the input transfer.
  assign wave[0].vld   = start_q;
  assign wave[0].found = 1'b0;
  assign wave[0].idx   = '0;

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    ptbs_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .item_i(item),
      .wave_i(wave[g]),
      .wave_o(wave[g+1])
    );
  end

  // A finished walk retires once the output register is free or being emptied.
  assign finish = pend_q && (!out_valid_q || out_ready_i);

  always_comb begin
    busy_d      = busy_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    running_d   = running_q;
    idle_d      = idle_q;
    switch_d    = switch_q;
    best_d      = wave[MAX_TASKS].found ? wave[MAX_TASKS].idx : '0;
    sw_d        = 1'b0;
    added_d     = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_xfer) begin
      busy_d = 1'b1;
    end
    if (wave[MAX_TASKS].vld) begin
      pend_d = 1'b1;
    end

    if (finish) begin
      pend_d      = 1'b0;
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (op_q == ptbs_pkg::OP_TICK) begin
        if (best_d != running_q) begin
          running_d = best_d;
          sw_d      = 1'b1;
        end
      end else if (op_q == ptbs_pkg::OP_ADD) begin
        if (count_q < MaxCnt) begin
          count_d = count_q + 1'b1;
          added_d = 1'b1;
        end
      end else if (op_q == ptbs_pkg::OP_DONE) begin
        if (running_q != '0) begin
          if (best_d == '0) begin
            running_d = '0;
            idle_d    = idle_q + 1'b1;
          end else begin
            running_d = best_d;
            switch_d  = switch_q + 1'b1;
            sw_d      = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      running_q   <= '0;
      idle_q      <= '0;
      switch_q    <= '0;
    end else begin
      busy_q      <= busy_d;
      start_q     <= in_xfer;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      running_q   <= running_d;
      idle_q      <= idle_d;
      switch_q    <= switch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_i;
      dly_q <= start_delay_i;
      per_q <= reload_period_i;
    end
    if (finish) begin
      best_q  <= best_d;
      sw_q    <= sw_d;
      added_q <= added_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign highest_task_o = best_q;
  assign current_task_o = running_q;
  assign switch_now_o   = sw_q;
  assign add_ok_o       = added_q;
  assign idle_count_o   = idle_q;
  assign switch_count_o = switch_q;

endmodule

### sv/ptbs_cell.sv
`timescale 1ns / 1ps

module ptbs_cell #(
  parameter int IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ptbs_pkg::item_t       item_i,
  input  ptbs_pkg::wave_t       wave_i,
  output ptbs_pkg::wave_t       wave_o
);

  localparam logic [ptbs_pkg::CNT_W-1:0]  MyCnt = ptbs_pkg::CNT_W'(IDX);
  localparam logic [ptbs_pkg::TASK_W-1:0] MyIdx = ptbs_pkg::TASK_W'(IDX);

  logic                        ready_q, ready_d;
  logic [ptbs_pkg::TIME_W-1:0] delay_q, delay_d;
  logic [ptbs_pkg::TIME_W-1:0] period_q, period_d;
  logic                        vld_q;
  logic                        found_q, found_d;
  logic [ptbs_pkg::TASK_W-1:0] idx_q, idx_d;

  always_comb begin
    ready_d  = ready_q;
    delay_d  = delay_q;
    period_d = period_q;
    if ((item_i.op == ptbs_pkg::OP_TICK) && (MyCnt != '0) && (MyCnt < item_i.count)) begin
      if (delay_q == '0) begin
        ready_d = 1'b1;
        delay_d = period_q;
      end else begin
        delay_d = delay_q - 1'b1;
      end
    end
    if ((item_i.op == ptbs_pkg::OP_ADD) && (MyCnt == item_i.count)) begin
      delay_d  = item_i.dly;
      period_d = item_i.per;
    end
    if ((item_i.op == ptbs_pkg::OP_DONE) && (item_i.running != '0) &&
        (item_i.running == MyIdx)) begin
      ready_d = 1'b0;
    end
    found_d = wave_i.found | ready_d;
    idx_d   = wave_i.found ? wave_i.idx : MyIdx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= wave_i.vld;
      if (wave_i.vld) begin
        ready_q <= ready_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wave_i.vld) begin
      delay_q  <= delay_d;
      period_q <= period_d;
      found_q  <= found_d;
      idx_q    <= idx_d;
    end
  end

  assign wave_o.vld   = vld_q;
  assign wave_o.found = found_q;
  assign wave_o.idx   = idx_q;

endmodule

### sv/ptbs_checker.sv
`timescale 1ns / 1ps

module ptbs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ptbs_pkg::TASK_W-1:0] highest_task_o,
  input logic [ptbs_pkg::TASK_W-1:0] current_task_o,
  input logic                        switch_now_o,
  input logic                        add_ok_o
);

  // A held result keeps its highest task, current task and switch flag.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(highest_task_o)
      && $stable(current_task_o) && $stable(switch_now_o))
    else $error("result changed while stalled");

  // Only one item is in flight: an input transfer closes the input side.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // An ordered switch always goes to the chosen highest ready task.
  a_switch_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && switch_now_o |-> (current_task_o == highest_task_o)
      && (current_task_o != '0))
    else $error("switch to wrong task");

  // An add never orders a switch.
  a_add_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && add_ok_o |-> !switch_now_o)
    else $error("add reported a switch");

endmodule

bind periodic_task_bitmap_scheduler ptbs_checker u_ptbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .highest_task_o(highest_task_o),
  .current_task_o(current_task_o),
  .switch_now_o  (switch_now_o),
  .add_ok_o      (add_ok_o)
);

### verif/tb_periodic_task_bitmap_scheduler.sv
`timescale 1ns / 1ps

// Testbench for the periodic task scheduler. It keeps its own copy of the task table
// (delays, periods, ready bits, running task, event counters) and works out the status
// that each accepted operation must return. Every result transfer is checked field by
// field against the oldest pending status, in order.
//
// Stimulus goes through a series of test tasks. They start with corner cases at reset,
// then a hand-written release, preemption and retire sequence. The table is then filled
// up to the full case. A long receiver hold-off and a full drain pause follow. The run
// ends with a long stretch of mixed operations.
//
// The sender works in bursts with gaps between them. The receiver stalls in phases of
// changing density, including phases with no stall at all.
module tb_periodic_task_bitmap_scheduler;

  localparam int NUM_SLOTS    = 16;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int LATENCY      = NUM_SLOTS + 3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 1000;

  // The package names only three operations; the fourth code must be ignored.
  localparam logic [ptbs_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  // One scheduler status as it appears on the output ports.
  typedef struct {
    logic [ptbs_pkg::TASK_W-1:0] highest;
    logic [ptbs_pkg::TASK_W-1:0] current;
    logic                        switched;
    logic                        added;
    logic [ptbs_pkg::EVT_W-1:0]  idle_cnt;
    logic [ptbs_pkg::EVT_W-1:0]  switch_cnt;
  } sched_status_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [ptbs_pkg::OP_W-1:0]     op_i = ptbs_pkg::OP_TICK;
  logic [ptbs_pkg::TIME_W-1:0]   start_delay_i = '0;
  logic [ptbs_pkg::TIME_W-1:0]   reload_period_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [ptbs_pkg::TASK_W-1:0]   highest_task_o;
  logic [ptbs_pkg::TASK_W-1:0]   current_task_o;
  logic                          switch_now_o;
  logic                          add_ok_o;
  logic [ptbs_pkg::EVT_W-1:0]    idle_count_o;
  logic [ptbs_pkg::EVT_W-1:0]    switch_count_o;

  // This copy of the task table follows the accepted transfers. Delays and periods are
  // read only below the task count, so entries that were never written are never looked at.
  logic [ptbs_pkg::TIME_W-1:0]   task_delay [NUM_SLOTS];
  logic [ptbs_pkg::TIME_W-1:0]   task_period [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]          task_ready = '0;
  logic [ptbs_pkg::CNT_W-1:0]    task_total = '0;
  logic [ptbs_pkg::TASK_W-1:0]   running = '0;
  logic [ptbs_pkg::EVT_W-1:0]    idle_fallbacks = '0;
  logic [ptbs_pkg::EVT_W-1:0]    ready_switches = '0;

  sched_status_t expected_status[$];
  int            error_count = 0;
  int            cycle_count = 0;

  // Sender burst bookkeeping and the receiver's stall pattern.
  int burst_left = 0;
  int hold_request = 0;
  int hold_left = 0;
  int stall_pct = 0;
  int stall_phase_left = 0;

  periodic_task_bitmap_scheduler #(
    .MAX_TASKS(NUM_SLOTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .op_i           (op_i),
    .start_delay_i  (start_delay_i),
    .reload_period_i(reload_period_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .highest_task_o (highest_task_o),
    .current_task_o (current_task_o),
    .switch_now_o   (switch_now_o),
    .add_ok_o       (add_ok_o),
    .idle_count_o   (idle_count_o),
    .switch_count_o (switch_count_o)
  );

  always #4 clk_i = ~clk_i;

  // A hard limit on the run. It stays far above the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [ptbs_pkg::TASK_W-1:0] lowest_ready_slot();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (task_ready[i]) return ptbs_pkg::TASK_W'(i);
    end
    return '0;
  endfunction

  function automatic logic [ptbs_pkg::TIME_W-1:0] rand16();
    return ptbs_pkg::TIME_W'($urandom());
  endfunction

  // Apply one accepted operation to the table copy and queue the status it must return.
  task automatic predict_schedule(input logic [ptbs_pkg::OP_W-1:0] op,
                                  input logic [ptbs_pkg::TIME_W-1:0] dly,
                                  input logic [ptbs_pkg::TIME_W-1:0] per);
    sched_status_t               st;
    logic [ptbs_pkg::TASK_W-1:0] best;
    st = '{default: '0};
    case (op)
      ptbs_pkg::OP_TICK: begin
        // The idle slot is skipped. Each other added task is released and reloaded,
        // or else its delay counts down by one.
        for (int i = 1; i < NUM_SLOTS; i++) begin
          if (i < task_total) begin
            if (task_delay[i] == '0) begin
              task_ready[i] = 1'b1;
              task_delay[i] = task_period[i];
            end else begin
              task_delay[i] = task_delay[i] - 1'b1;
            end
          end
        end
        best = lowest_ready_slot();
        if (best != running) begin
          running     = best;
          st.switched = 1'b1;
        end
      end
      ptbs_pkg::OP_ADD: begin
        if (task_total < NUM_SLOTS) begin
          task_delay[task_total[SLOT_W-1:0]]  = dly;
          task_period[task_total[SLOT_W-1:0]] = per;
          task_total                          = task_total + 1'b1;
          st.added                            = 1'b1;
        end
        best = lowest_ready_slot();
      end
      ptbs_pkg::OP_DONE: begin
        if (running != '0) begin
          task_ready[running[SLOT_W-1:0]] = 1'b0;
          best = lowest_ready_slot();
          if (best == '0) begin
            // The scheduler falls back to idle. No switch is ordered for this.
            running        = '0;
            idle_fallbacks = idle_fallbacks + 1'b1;
          end else begin
            ready_switches = ready_switches + 1'b1;
            running        = best;
            st.switched    = 1'b1;
          end
        end else begin
          best = lowest_ready_slot();
        end
      end
      default: best = lowest_ready_slot();
    endcase
    st.highest    = best;
    st.current    = running;
    st.idle_cnt   = idle_fallbacks;
    st.switch_cnt = ready_switches;
    expected_status.push_back(st);
  endtask

  task automatic report_mismatch(input string what, input logic [ptbs_pkg::EVT_W-1:0] got,
                                 input logic [ptbs_pkg::EVT_W-1:0] want);
    $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Send one operation. The task is entered and left at a rising edge, and valid stays
  // high on return so that the next item of a burst follows without a bubble. The
  // handshake is sampled at the falling edge, where all ports are settled. If ready is
  // high there, the transfer happens at the next rising edge.
  task automatic send_item(input logic [ptbs_pkg::OP_W-1:0] op,
                           input logic [ptbs_pkg::TIME_W-1:0] dly,
                           input logic [ptbs_pkg::TIME_W-1:0] per);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    op_i            <= op;
    start_delay_i   <= dly;
    reload_period_i <= per;
    do @(negedge clk_i); while (!in_ready_o);
    predict_schedule(op, dly, per);
    @(posedge clk_i);
  endtask

  // The sender stops until every pending status has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_status.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: a long hold-off when one is requested, otherwise phases of random length
  // with a stall density drawn per phase (zero included).
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_phase_left == 0) begin
        stall_phase_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      stall_phase_left--;
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker. The ports are sampled at the falling edge before the transfer edge.
  always @(negedge clk_i) begin
    sched_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status.size() == 0) begin
        report_mismatch("unexpected result, current_task",
                        ptbs_pkg::EVT_W'(current_task_o), '0);
      end else begin
        want = expected_status.pop_front();
        if (highest_task_o !== want.highest)
          report_mismatch("highest_task", ptbs_pkg::EVT_W'(highest_task_o),
                          ptbs_pkg::EVT_W'(want.highest));
        if (current_task_o !== want.current)
          report_mismatch("current_task", ptbs_pkg::EVT_W'(current_task_o),
                          ptbs_pkg::EVT_W'(want.current));
        if (switch_now_o !== want.switched)
          report_mismatch("switch_now", ptbs_pkg::EVT_W'(switch_now_o),
                          ptbs_pkg::EVT_W'(want.switched));
        if (add_ok_o !== want.added)
          report_mismatch("add_ok", ptbs_pkg::EVT_W'(add_ok_o),
                          ptbs_pkg::EVT_W'(want.added));
        if (idle_count_o !== want.idle_cnt)
          report_mismatch("idle_count", idle_count_o, want.idle_cnt);
        if (switch_count_o !== want.switch_cnt)
          report_mismatch("switch_count", switch_count_o, want.switch_cnt);
      end
    end
  end

  // Operations on an empty table: an unused code, a done while idle, and a tick with
  // nothing to release. Then the idle slot is added with all-ones fields. The idle slot
  // must never be released, so the tick after it leaves the scheduler idle.
  task automatic test_reset_corners();
    send_item(OP_UNUSED, 16'hFFFF, 16'h0000);
    send_item(ptbs_pkg::OP_DONE, 16'h0000, 16'hFFFF);
    send_item(ptbs_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(ptbs_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
    send_item(ptbs_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
    send_item(ptbs_pkg::OP_DONE, 16'h0000, 16'h0000);
  endtask

  // Three real tasks. Slot 2 has a zero delay and period, so it is released on every
  // tick. Slot 1 comes up a few ticks later and preempts slot 2. Slot 3 has the largest
  // delay and never comes up. The dones cover both a switch to a waiting task and a
  // fall-back to idle.
  task automatic test_release_and_retire();
    send_item(ptbs_pkg::OP_ADD, 16'd2, 16'd5);
    send_item(ptbs_pkg::OP_ADD, 16'd0, 16'd0);
    send_item(ptbs_pkg::OP_ADD, 16'hFFFF, 16'hFFFF);
    send_item(ptbs_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(ptbs_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_item(ptbs_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(ptbs_pkg::OP_TICK, 16'h0000, 16'h0000);
    send_item(ptbs_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_item(ptbs_pkg::OP_DONE, 16'h0000, 16'h0000);
    send_item(OP_UNUSED, 16'h5A5A, 16'hA5A5);
  endtask

  // Fill the remaining slots with short random periods and some ticks in between. Then
  // add once more: the table is full and the add must fail.
  task automatic test_fill_table();
    while (task_total < NUM_SLOTS) begin
      send_item(ptbs_pkg::OP_ADD, ptbs_pkg::TIME_W'($urandom_range(0, 30)),
                ptbs_pkg::TIME_W'($urandom_range(0, 40)));
      if ($urandom_range(0, 1) == 1) send_item(ptbs_pkg::OP_TICK, rand16(), rand16());
    end
    send_item(ptbs_pkg::OP_ADD, rand16(), rand16());
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering ticks and
  // dones back to back. The block fills up and must stall its input.
  task automatic test_output_backpressure();
    wait_drained();
    hold_request = 300;
    burst_left   = 12;
    repeat (12) begin
      send_item(($urandom_range(0, 1) == 0) ? ptbs_pkg::OP_TICK : ptbs_pkg::OP_DONE,
                rand16(), rand16());
    end
  endtask

  // Mixed traffic on the full table. It is mostly ticks and dones, so that releases,
  // preemption and retirement keep happening. Late adds with full-range fields all fail.
  // Unused codes are mixed in, and now and then the sender pauses until all is drained.
  task automatic test_random_traffic();
    int                        pick;
    logic [ptbs_pkg::OP_W-1:0] op;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50)      op = ptbs_pkg::OP_TICK;
      else if (pick < 85) op = ptbs_pkg::OP_DONE;
      else if (pick < 93) op = ptbs_pkg::OP_ADD;
      else                op = OP_UNUSED;
      send_item(op, rand16(), rand16());
      if (n % 250 == 249) wait_drained();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_corners();
    test_release_and_retire();
    test_fill_table();
    test_output_backpressure();
    test_random_traffic();

    // Wait for the pending statuses. Then wait a few more walks, so that a stray extra
    // result would still be caught.
    wait_drained();
    repeat (3 * LATENCY) @(posedge clk_i);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
